### sv/imme_pkg.sv
// Shared types and constants of the integer matrix multiply engine.
`timescale 1ns / 1ps

package imme_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_WR_A    = 2'd0,
        FUNC_WR_B    = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_WAIT,
        ST_DRAIN
    } state_t;

    localparam logic [1:0] REG_ROWS_M       = 2'd0;
    localparam logic [1:0] REG_COLS_N       = 2'd1;
    localparam logic [1:0] REG_INNER_K      = 2'd2;
    localparam logic [1:0] REG_B_TRANSPOSED = 2'd3;

    typedef struct packed {
        logic shift;
        logic mac;
        logic first;
    } ring_ctl_t;

endpackage

### sv/imme_cell.sv
// One accumulator cell of the ring: holds a partial sum and passes it on.
`timescale 1ns / 1ps

module imme_cell #(
    parameter int DATA_WIDTH = imme_pkg::DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [DATA_WIDTH-1:0] d,
    output logic [DATA_WIDTH-1:0] q
);

    logic [DATA_WIDTH-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= d;
        end
    end

    assign q = sum_reg;

endmodule

### sv/imme_ring.sv
// Ring of accumulator cells with the head adder and the tail select.
`timescale 1ns / 1ps

module imme_ring #(
    parameter int MAX_DIM    = imme_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = imme_pkg::DATA_WIDTH_DEF,
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                  aclk,
    input  imme_pkg::ring_ctl_t   ctl,
    input  logic [DATA_WIDTH-1:0] prod,
    input  logic [IDX_W-1:0]      tail_sel,
    output logic [DATA_WIDTH-1:0] tail
);

    logic [DATA_WIDTH-1:0] chain [MAX_DIM];
    logic [DATA_WIDTH-1:0] head;

    always_comb begin
        if (ctl.mac) begin
            head = ctl.first ? prod : tail + prod;
        end else begin
            head = tail;
        end
    end

    assign tail = chain[tail_sel];

    for (genvar i = 0; i < MAX_DIM; i++) begin : g_cell
        if (i == 0) begin : g_head
            imme_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .aclk (aclk),
                .en   (ctl.shift),
                .d    (head),
                .q    (chain[i])
            );
        end else begin : g_body
            imme_cell #(.DATA_WIDTH(DATA_WIDTH)) u_cell (
                .aclk (aclk),
                .en   (ctl.shift),
                .d    (chain[i-1]),
                .q    (chain[i])
            );
        end
    end

endmodule

### sv/int_matrix_multiply_engine_unit.sv
// Top level of the integer matrix multiply engine: stores, sequencer, multiplier, ports.
// Write requests are accepted back to back while idle.
// A compute request runs row by row: N*K multiply-accumulate steps through a
// three-stage read/multiply/accumulate path into a ring of N accumulator cells, a wait
// to settle, then a drain of N results that stalls under backpressure.
// aresetn (synchronous, active low) clears control, the output valid and the
// registers to M=N=K=8, untransposed; store contents are undefined until written.
`timescale 1ns / 1ps

module int_matrix_multiply_engine_unit #(
    parameter int MAX_DIM    = imme_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = imme_pkg::DATA_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // elem_index[5:0], elem_value[37:6], zero[39:38]
    input  logic [1:0]  s_tuser,   // func[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // c_value[31:0], c_row[34:32], c_col[37:35], zero[39:38]
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (MAX_DIM > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(MAX_DIM + 1);

    // configuration
    logic [3:0] rows_m_reg, cols_n_reg, inner_k_reg;
    logic       b_transposed_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg       <= 4'd8;
            cols_n_reg       <= 4'd8;
            inner_k_reg      <= 4'd8;
            b_transposed_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                imme_pkg::REG_ROWS_M:       rows_m_reg       <= pwdata[3:0];
                imme_pkg::REG_COLS_N:       cols_n_reg       <= pwdata[3:0];
                imme_pkg::REG_INNER_K:      inner_k_reg      <= pwdata[3:0];
                imme_pkg::REG_B_TRANSPOSED: b_transposed_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            imme_pkg::REG_ROWS_M:       prdata = {28'd0, rows_m_reg};
            imme_pkg::REG_COLS_N:       prdata = {28'd0, cols_n_reg};
            imme_pkg::REG_INNER_K:      prdata = {28'd0, inner_k_reg};
            imme_pkg::REG_B_TRANSPOSED: prdata = {31'd0, b_transposed_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // clamped dimensions
    logic [CNT_W-1:0] dim_m, dim_n, dim_k;

    always_comb begin
        if (rows_m_reg == 4'd0) begin
            dim_m = CNT_W'(1);
        end else if (rows_m_reg > 4'(MAX_DIM)) begin
            dim_m = CNT_W'(MAX_DIM);
        end else begin
            dim_m = rows_m_reg[CNT_W-1:0];
        end
        if (cols_n_reg == 4'd0) begin
            dim_n = CNT_W'(1);
        end else if (cols_n_reg > 4'(MAX_DIM)) begin
            dim_n = CNT_W'(MAX_DIM);
        end else begin
            dim_n = cols_n_reg[CNT_W-1:0];
        end
        if (inner_k_reg == 4'd0) begin
            dim_k = CNT_W'(1);
        end else if (inner_k_reg > 4'(MAX_DIM)) begin
            dim_k = CNT_W'(MAX_DIM);
        end else begin
            dim_k = inner_k_reg[CNT_W-1:0];
        end
    end

    logic [IDX_W-1:0] m_max, n_max, k_max;

    assign m_max = IDX_W'(dim_m - CNT_W'(1));
    assign n_max = IDX_W'(dim_n - CNT_W'(1));
    assign k_max = IDX_W'(dim_k - CNT_W'(1));

    // stores
    logic [DATA_WIDTH-1:0] a_mem [DEPTH];
    logic [DATA_WIDTH-1:0] b_mem [DEPTH];
    logic [DATA_WIDTH-1:0] a_rd_reg, b_rd_reg;
    logic [5:0]            wr_idx;
    logic                  wr_in_range;
    logic                  wr_a, wr_b;
    logic                  in_accept;

    assign in_accept   = s_tvalid && s_tready;
    assign wr_idx      = s_tdata[5:0];
    assign wr_in_range = 7'(wr_idx) < 7'(DEPTH);

    always_comb begin
        wr_a = 1'b0;
        wr_b = 1'b0;
        case (s_tuser)
            imme_pkg::FUNC_WR_A: wr_a = in_accept && wr_in_range;
            imme_pkg::FUNC_WR_B: wr_b = in_accept && wr_in_range;
            default: ;
        endcase
    end

    // sequencer
    imme_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0]  m_cnt_reg, m_cnt_next;
    logic [IDX_W-1:0]  n_cnt_reg, n_cnt_next;
    logic [IDX_W-1:0]  k_cnt_reg, k_cnt_next;
    logic [ADDR_W-1:0] a_base_reg, a_base_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0] a_addr;
    logic              issue, issue_first, issue_end;
    logic              drain_shift;
    logic              out_free;

    logic              rd_valid_reg, rd_first_reg, rd_end_reg;
    logic              mul_valid_reg, mul_first_reg, mul_end_reg;
    logic [DATA_WIDTH-1:0] prod_reg;
    logic [DATA_WIDTH-1:0] tail;

    logic              m_tvalid_reg;
    logic [31:0]       out_value_reg;
    logic [2:0]        out_row_reg, out_col_reg;
    logic              out_last_reg;

    assign a_addr   = a_base_reg + ADDR_W'(k_cnt_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            a_mem[wr_idx[ADDR_W-1:0]] <= s_tdata[6 +: DATA_WIDTH];
        end
        if (wr_b) begin
            b_mem[wr_idx[ADDR_W-1:0]] <= s_tdata[6 +: DATA_WIDTH];
        end
        if (issue) begin
            a_rd_reg <= a_mem[a_addr];
            b_rd_reg <= b_mem[b_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= imme_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        m_cnt_reg  <= m_cnt_next;
        n_cnt_reg  <= n_cnt_next;
        k_cnt_reg  <= k_cnt_next;
        a_base_reg <= a_base_next;
        b_addr_reg <= b_addr_next;
    end

    always_comb begin
        state_next  = state_reg;
        m_cnt_next  = m_cnt_reg;
        n_cnt_next  = n_cnt_reg;
        k_cnt_next  = k_cnt_reg;
        a_base_next = a_base_reg;
        b_addr_next = b_addr_reg;
        s_tready    = 1'b0;
        issue       = 1'b0;
        issue_first = 1'b0;
        issue_end   = 1'b0;
        drain_shift = 1'b0;
        case (state_reg)
            imme_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == imme_pkg::FUNC_COMPUTE) begin
                    state_next  = imme_pkg::ST_ACC;
                    m_cnt_next  = '0;
                    n_cnt_next  = '0;
                    k_cnt_next  = '0;
                    a_base_next = '0;
                    b_addr_next = '0;
                end
            end
            imme_pkg::ST_ACC: begin
                issue       = 1'b1;
                issue_first = k_cnt_reg == '0;
                issue_end   = (k_cnt_reg == k_max) && (n_cnt_reg == n_max);
                if (n_cnt_reg == n_max) begin
                    n_cnt_next = '0;
                    if (k_cnt_reg == k_max) begin
                        k_cnt_next  = '0;
                        b_addr_next = '0;
                        state_next  = imme_pkg::ST_WAIT;
                    end else begin
                        k_cnt_next  = k_cnt_reg + IDX_W'(1);
                        b_addr_next = b_transposed_reg
                                    ? ADDR_W'(k_cnt_reg) + ADDR_W'(1)
                                    : b_addr_reg + ADDR_W'(1);
                    end
                end else begin
                    n_cnt_next  = n_cnt_reg + IDX_W'(1);
                    b_addr_next = b_transposed_reg
                                ? b_addr_reg + ADDR_W'(dim_k)
                                : b_addr_reg + ADDR_W'(1);
                end
            end
            imme_pkg::ST_WAIT: begin
                if (mul_valid_reg && mul_end_reg) begin
                    n_cnt_next = '0;
                    state_next = imme_pkg::ST_DRAIN;
                end
            end
            imme_pkg::ST_DRAIN: begin
                if (out_free) begin
                    drain_shift = 1'b1;
                    n_cnt_next  = n_cnt_reg + IDX_W'(1);
                    if (n_cnt_reg == n_max) begin
                        n_cnt_next = '0;
                        if (m_cnt_reg == m_max) begin
                            state_next = imme_pkg::ST_IDLE;
                        end else begin
                            m_cnt_next  = m_cnt_reg + IDX_W'(1);
                            a_base_next = a_base_reg + ADDR_W'(dim_k);
                            k_cnt_next  = '0;
                            state_next  = imme_pkg::ST_ACC;
                        end
                    end
                end
            end
            default: begin
                state_next = imme_pkg::ST_IDLE;
            end
        endcase
    end

    // read and multiply stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg  <= issue;
            mul_valid_reg <= rd_valid_reg;
        end
        rd_first_reg  <= issue_first;
        rd_end_reg    <= issue_end;
        mul_first_reg <= rd_first_reg;
        mul_end_reg   <= rd_end_reg;
        if (rd_valid_reg) begin
            prod_reg <= a_rd_reg * b_rd_reg;
        end
    end

    // accumulator ring
    imme_pkg::ring_ctl_t ring_ctl;

    always_comb begin
        ring_ctl.shift = mul_valid_reg || drain_shift;
        ring_ctl.mac   = mul_valid_reg;
        ring_ctl.first = mul_first_reg;
    end

    imme_ring #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ring (
        .aclk     (aclk),
        .ctl      (ring_ctl),
        .prod     (prod_reg),
        .tail_sel (n_max),
        .tail     (tail)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (drain_shift) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (drain_shift) begin
            out_value_reg <= 32'($signed(tail));
            out_row_reg   <= 3'(m_cnt_reg);
            out_col_reg   <= 3'(n_cnt_reg);
            out_last_reg  <= (m_cnt_reg == m_max) && (n_cnt_reg == n_max);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_col_reg, out_row_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule
